FILE: sv/pps_pkg.sv
// ----------------------------------------------------------------------------
// Packed parameter store package
// Shared widths, field layout constants and the types passed between the
// configuration registers, the row unit and the top level.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int WIDTH_W   = 5;
  localparam int MAX_WIDTH = 16;
  localparam int VALUE_W   = 16;
  localparam int SOUND_W   = 3;
  localparam int FIELD_W   = 3;
  localparam int OFFSET_W  = 7;
  localparam int EXT_W     = NUM_REGS * MAX_WIDTH;

  localparam int SOUNDS_DEFAULT    = 6;
  localparam int FIELDS_DEFAULT    = 6;
  localparam int ROW_BYTES_DEFAULT = 6;

  localparam logic [NUM_REGS-1:0][WIDTH_W-1:0] WIDTH_RESET =
    {5'd8, 5'd8, 5'd3, 5'd8, 5'd8, 5'd10};

  typedef enum logic {
    MODE_READ  = 1'b0,
    MODE_WRITE = 1'b1
  } mode_t;

  typedef struct packed {
    logic [NUM_REGS-1:0][OFFSET_W-1:0] offset;
    logic [NUM_REGS-1:0][WIDTH_W-1:0]  width;
  } layout_t;

  typedef struct packed {
    mode_t              mode;
    logic [SOUND_W-1:0] sound;
    logic [FIELD_W-1:0] field;
    logic [VALUE_W-1:0] value;
  } access_t;

endpackage

FILE: sv/pps_cfg_regs.sv
// ----------------------------------------------------------------------------
// Packed parameter store field width registers
// Holds the field width registers and derives the saturated widths and the
// bit offset of every field within a row.
// ----------------------------------------------------------------------------
module pps_cfg_regs
  import pps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH_W-1:0]   cfg_data,
  output layout_t              layout
);

  logic [NUM_REGS-1:0][WIDTH_W-1:0] width_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= WIDTH_RESET;
    end else if (cfg_write) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          width_reg[i] <= cfg_data;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      if (width_reg[i] > WIDTH_W'(MAX_WIDTH)) begin
        layout.width[i] = WIDTH_W'(MAX_WIDTH);
      end else begin
        layout.width[i] = width_reg[i];
      end
    end
    layout.offset[0] = '0;
    for (int i = 1; i < NUM_REGS; i++) begin
      layout.offset[i] = layout.offset[i-1] + OFFSET_W'(layout.width[i-1]);
    end
  end

`ifndef SYNTHESIS
  property p_width_saturated;
    @(posedge clk) disable iff (rst)
      layout.width[0] <= WIDTH_W'(MAX_WIDTH) && layout.width[NUM_REGS-1] <= WIDTH_W'(MAX_WIDTH);
  endproperty
  a_width_saturated: assert property (p_width_saturated)
    else $error("saturated field width exceeds the maximum");
`endif

endmodule

FILE: sv/pps_row_unit.sv
// ----------------------------------------------------------------------------
// Packed parameter store row unit
// Holds the sound rows and performs the field extract or insert for one
// access, registering the field value as it reads after the access.
// ----------------------------------------------------------------------------
module pps_row_unit
  import pps_pkg::*;
#(
  parameter int SOUNDS    = SOUNDS_DEFAULT,
  parameter int FIELDS    = FIELDS_DEFAULT,
  parameter int ROW_BYTES = ROW_BYTES_DEFAULT
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  access_t            access,
  input  layout_t            layout,
  output logic [VALUE_W-1:0] field_value
);

  localparam int ROW_BITS = ROW_BYTES * 8;
  localparam int DEPTH    = (SOUNDS < (1 << SOUND_W)) ? SOUNDS : (1 << SOUND_W);
  localparam int SIDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [EXT_W-1:0] ROW_MASK = (EXT_W'(1) << ROW_BITS) - EXT_W'(1);

  logic [ROW_BITS-1:0] rows [DEPTH];

  logic [SIDX_W-1:0]   row_idx;
  logic                in_range;
  logic [WIDTH_W-1:0]  width;
  logic [OFFSET_W-1:0] offset;
  logic [VALUE_W-1:0]  fmask;
  logic [EXT_W-1:0]    place_mask;
  logic [EXT_W-1:0]    row_ext;
  logic [EXT_W-1:0]    row_new;
  logic [VALUE_W-1:0]  field_value_next;

  always_comb begin
    row_idx    = access.sound[SIDX_W-1:0];
    in_range   = (32'(access.sound) < SOUNDS) && (32'(access.field) < FIELDS);
    width      = layout.width[access.field];
    offset     = layout.offset[access.field];
    fmask      = ~({VALUE_W{1'b1}} << width);
    place_mask = (EXT_W'(fmask) << offset) & ROW_MASK;
    row_ext    = EXT_W'(rows[row_idx]);
    if (access.mode == MODE_WRITE) begin
      row_new = (row_ext & ~place_mask) | ((EXT_W'(access.value) << offset) & place_mask);
    end else begin
      row_new = row_ext;
    end
    if (in_range) begin
      field_value_next = VALUE_W'((row_new & place_mask) >> offset);
    end else begin
      field_value_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      field_value <= field_value_next;
      if (in_range && access.mode == MODE_WRITE) begin
        rows[row_idx] <= row_new[ROW_BITS-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  property p_value_within_width;
    @(posedge clk) disable iff (rst)
      step |=> (field_value & ~$past(fmask)) == '0;
  endproperty
  a_value_within_width: assert property (p_value_within_width)
    else $error("field value has bits above the field width");

  property p_out_of_range_zero;
    @(posedge clk) disable iff (rst)
      step && !in_range |=> field_value == '0;
  endproperty
  a_out_of_range_zero: assert property (p_out_of_range_zero)
    else $error("access outside the store did not return zero");
`endif

endmodule

FILE: sv/packed_parameter_store.sv
// ----------------------------------------------------------------------------
// Packed parameter store
// Per-sound parameter rows of variable-width packed fields, with field
// read and field write access.
// ----------------------------------------------------------------------------
// One access can be accepted in every cycle while req_stall is low: the request
// is captured in an input register, and the row read, field extract or insert,
// and row write-back happen from that register ahead of the result register.
// The request side stalls only while both the input register and the result
// register hold a transfer and the result is stalled. A write returns the field
// as it now reads back. Configuration writes are always accepted and should
// only be issued while no access is in flight.
module packed_parameter_store
  import pps_pkg::*;
#(
  parameter int SOUNDS    = SOUNDS_DEFAULT,
  parameter int FIELDS    = FIELDS_DEFAULT,
  parameter int ROW_BYTES = ROW_BYTES_DEFAULT
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH_W-1:0]   cfg_data,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic                 mode,
  input  logic [SOUND_W-1:0]   sound_index,
  input  logic [FIELD_W-1:0]   field_index,
  input  logic [VALUE_W-1:0]   write_value,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [VALUE_W-1:0]   field_value
);

  layout_t layout;
  access_t access;
  logic    access_valid;
  logic    advance;
  logic    accept;
  logic    step;

  assign cfg_ready = 1'b1;
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = access_valid && !advance;
  assign accept    = req_valid && !req_stall;
  assign step      = access_valid && advance;

  pps_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .layout    (layout)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      access_valid <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      if (accept) begin
        access_valid <= 1'b1;
      end else if (advance) begin
        access_valid <= 1'b0;
      end
      if (step) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      access.mode  <= mode_t'(mode);
      access.sound <= sound_index;
      access.field <= field_index;
      access.value <= write_value;
    end
  end

  pps_row_unit #(
    .SOUNDS    (SOUNDS),
    .FIELDS    (FIELDS),
    .ROW_BYTES (ROW_BYTES)
  ) u_row_unit (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .access      (access),
    .layout      (layout),
    .field_value (field_value)
  );

`ifndef SYNTHESIS
  property p_accept_loads_stage;
    @(posedge clk) disable iff (rst)
      accept |=> access_valid;
  endproperty
  a_accept_loads_stage: assert property (p_accept_loads_stage)
    else $error("accepted transfer was not captured");

  property p_step_gives_result;
    @(posedge clk) disable iff (rst)
      step |=> rsp_valid;
  endproperty
  a_step_gives_result: assert property (p_step_gives_result)
    else $error("processed access produced no result");

  property p_full_pipe_stalls;
    @(posedge clk) disable iff (rst)
      access_valid && rsp_valid && rsp_stall |-> req_stall;
  endproperty
  a_full_pipe_stalls: assert property (p_full_pipe_stalls)
    else $error("request taken while both stages are held");
`endif

endmodule

FILE: tb/sv/tb_packed_parameter_store.sv
// ----------------------------------------------------------------------------
// Packed parameter store testbench
// Sends field read and write accesses to the store and predicts every
// returned field value from the directed table or a bit-level copy of the
// rows and the field widths. The directed accesses open the run, followed
// by random accesses under a series of width settings, including zero, one,
// saturating and over-long layouts. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_packed_parameter_store;
  import pps_pkg::*;

  localparam int SOUND_CNT   = SOUNDS_DEFAULT;
  localparam int FIELD_CNT   = FIELDS_DEFAULT;
  localparam int ROW_W       = ROW_BYTES_DEFAULT * 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_CNT  = 1600;
  localparam int SETTINGS    = 8;

  typedef struct {
    access_t            acc;
    bit                 typed;
    logic [VALUE_W-1:0] want;
  } stim_entry_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WIDTH_W-1:0]   cfg_data = '0;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  logic                 mode = 1'b0;
  logic [SOUND_W-1:0]   sound_index = '0;
  logic [FIELD_W-1:0]   field_index = '0;
  logic [VALUE_W-1:0]   write_value = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  logic [VALUE_W-1:0]   field_value;

  logic [WIDTH_W-1:0]   width_reg [NUM_REGS];
  logic [ROW_W-1:0]     row_bits [SOUND_CNT];
  logic [ROW_W-1:0]     written_bits [SOUND_CNT];
  logic [VALUE_W-1:0]   pending_field_values [$];
  logic [VALUE_W-1:0]   oldest_value;
  stim_entry_t          directed_table [$];

  int send_idle_pct  = 31;
  int recv_stall_pct = 62;
  int failures       = 0;
  int cycle_count    = 0;

  packed_parameter_store dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .mode        (mode),
    .sound_index (sound_index),
    .field_index (field_index),
    .write_value (write_value),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .field_value (field_value)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("packed_parameter_store verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_field_values.size() == 0) begin
        $error("field_value: no transfer expected, actual %h", field_value);
        failures++;
      end else begin
        oldest_value = pending_field_values.pop_front();
        if (field_value !== oldest_value) begin
          $error("field_value: expected %h, actual %h", oldest_value, field_value);
          failures++;
        end
      end
    end
  end

  function automatic int eff_width(int f);
    return (width_reg[f] > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg[f]);
  endfunction

  function automatic int field_base(int f);
    int sum;
    sum = 0;
    for (int j = 0; j < f; j++) sum += eff_width(j);
    return sum;
  endfunction

  // Applies one access to the predicted rows and returns the field as read back.
  function automatic logic [VALUE_W-1:0] access_row_store(access_t a);
    logic [VALUE_W-1:0] got;
    int w, base, pos;
    got = '0;
    if (a.sound < SOUND_CNT && a.field < FIELD_CNT) begin
      w = eff_width(a.field);
      base = field_base(a.field);
      for (int i = 0; i < w; i++) begin
        pos = base + i;
        if (pos < ROW_W) begin
          if (a.mode == MODE_WRITE) begin
            row_bits[a.sound][pos] = a.value[i];
            written_bits[a.sound][pos] = 1'b1;
          end
          got[i] = row_bits[a.sound][pos];
        end
      end
    end
    return got;
  endfunction

  function automatic bit field_fully_written(access_t a);
    int w, base;
    if (a.sound >= SOUND_CNT || a.field >= FIELD_CNT) return 1'b1;
    w = eff_width(a.field);
    base = field_base(a.field);
    for (int i = 0; i < w; i++) begin
      if (base + i < ROW_W && !written_bits[a.sound][base + i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic stim_entry_t stim_entry(mode_t m, int snd, int fld, logic [VALUE_W-1:0] v,
                                             bit typed, logic [VALUE_W-1:0] want);
    stim_entry_t e;
    e.acc.mode  = m;
    e.acc.sound = SOUND_W'(snd);
    e.acc.field = FIELD_W'(fld);
    e.acc.value = v;
    e.typed     = typed;
    e.want      = want;
    return e;
  endfunction

  task automatic send_access(access_t a, bit typed, logic [VALUE_W-1:0] want);
    logic [VALUE_W-1:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    mode        <= a.mode;
    sound_index <= a.sound;
    field_index <= a.field;
    write_value <= a.value;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = access_row_store(a);
    pending_field_values.push_back(typed ? want : predicted);
  endtask

  task automatic drain;
    req_valid <= 1'b0;
    while (pending_field_values.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WIDTH_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx < NUM_REGS) width_reg[idx] = data;
    @(posedge clk);
  endtask

  task automatic program_widths(logic [NUM_REGS-1:0][WIDTH_W-1:0] ws);
    for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_IDX_W'(i), ws[i]);
  endtask

  initial begin
    access_t                            a;
    logic [NUM_REGS-1:0][WIDTH_W-1:0]   ws;
    int                                 sent;

    for (int i = 0; i < NUM_REGS; i++) width_reg[i] = WIDTH_RESET[i];
    for (int s = 0; s < SOUND_CNT; s++) begin
      row_bits[s]     = '0;
      written_bits[s] = '0;
    end

    // With the reset widths the fields start at bits 0, 10, 18, 26, 29 and 37.
    directed_table.push_back(stim_entry(MODE_WRITE, 0, 0, 16'hFFFF, 1, 16'h03FF));
    directed_table.push_back(stim_entry(MODE_WRITE, 0, 1, 16'h0000, 1, 16'h0000));
    directed_table.push_back(stim_entry(MODE_WRITE, 0, 2, 16'hFFFF, 1, 16'h00FF));
    directed_table.push_back(stim_entry(MODE_WRITE, 0, 3, 16'hFFFF, 1, 16'h0007));
    directed_table.push_back(stim_entry(MODE_WRITE, 0, 4, 16'h0000, 1, 16'h0000));
    directed_table.push_back(stim_entry(MODE_WRITE, 0, 5, 16'hFFFF, 1, 16'h00FF));
    directed_table.push_back(stim_entry(MODE_READ,  0, 0, 16'hFFFF, 1, 16'h03FF));
    directed_table.push_back(stim_entry(MODE_READ,  0, 1, 16'hFFFF, 1, 16'h0000));
    directed_table.push_back(stim_entry(MODE_READ,  0, 3, 16'h0000, 1, 16'h0007));
    directed_table.push_back(stim_entry(MODE_READ,  0, 5, 16'h0000, 1, 16'h00FF));
    directed_table.push_back(stim_entry(MODE_WRITE, 5, 5, 16'hABCD, 1, 16'h00CD));
    directed_table.push_back(stim_entry(MODE_WRITE, 5, 0, 16'h5555, 1, 16'h0155));
    directed_table.push_back(stim_entry(MODE_READ,  5, 5, 16'h0000, 1, 16'h00CD));
    directed_table.push_back(stim_entry(MODE_WRITE, 6, 0, 16'hFFFF, 1, 16'h0000));
    directed_table.push_back(stim_entry(MODE_WRITE, 7, 2, 16'hFFFF, 1, 16'h0000));
    directed_table.push_back(stim_entry(MODE_READ,  7, 0, 16'hFFFF, 1, 16'h0000));
    directed_table.push_back(stim_entry(MODE_WRITE, 1, 6, 16'hFFFF, 1, 16'h0000));
    directed_table.push_back(stim_entry(MODE_WRITE, 1, 7, 16'hFFFF, 1, 16'h0000));
    directed_table.push_back(stim_entry(MODE_READ,  3, 7, 16'hFFFF, 1, 16'h0000));
    directed_table.push_back(stim_entry(MODE_WRITE, 2, 3, 16'($urandom), 0, '0));
    directed_table.push_back(stim_entry(MODE_WRITE, 3, 4, 16'($urandom), 0, '0));
    directed_table.push_back(stim_entry(MODE_READ,  2, 3, 16'($urandom), 0, '0));
    directed_table.push_back(stim_entry(MODE_WRITE, 4, 1, 16'($urandom), 0, '0));
    directed_table.push_back(stim_entry(MODE_READ,  4, 1, 16'($urandom), 0, '0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_table[i]) begin
      send_access(directed_table[i].acc, directed_table[i].typed, directed_table[i].want);
    end

    sent = 0;
    for (int setting = 0; setting < SETTINGS; setting++) begin
      drain();
      case (setting)
        0: ws = {NUM_REGS{5'd16}};
        1: ws = {NUM_REGS{5'd1}};
        2: ws = {5'd1, 5'd16, 5'd0, 5'd17, 5'd31, 5'd0};
        3: ws = {NUM_REGS{5'd31}};
        7: ws = WIDTH_RESET;
        default: begin
          for (int i = 0; i < NUM_REGS; i++) ws[i] = WIDTH_W'($urandom_range(31));
        end
      endcase
      program_widths(ws);
      if (setting == 2) begin
        write_reg(CFG_IDX_W'(NUM_REGS), WIDTH_W'($urandom_range(31)));
        write_reg(CFG_IDX_W'(NUM_REGS + 1), WIDTH_W'($urandom_range(31)));
      end

      for (int k = 0; k < RANDOM_CNT / SETTINGS; k++) begin
        if (sent < RANDOM_CNT / 3) begin
          send_idle_pct  = 31;
          recv_stall_pct = 62;
        end else if (sent < 2 * RANDOM_CNT / 3) begin
          send_idle_pct  = 62;
          recv_stall_pct = 31;
        end else begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        a.mode  = mode_t'($urandom_range(1));
        a.sound = ($urandom_range(9) == 0) ? SOUND_W'($urandom_range(7))
                                           : SOUND_W'($urandom_range(SOUND_CNT - 1));
        a.field = ($urandom_range(9) == 0) ? FIELD_W'($urandom_range(7))
                                           : FIELD_W'($urandom_range(FIELD_CNT - 1));
        case ($urandom_range(7))
          0: a.value = '0;
          1: a.value = '1;
          default: a.value = VALUE_W'($urandom);
        endcase
        // Field bits that were never stored may not be read back.
        if (a.mode == MODE_READ && !field_fully_written(a)) a.mode = MODE_WRITE;
        send_access(a, 1'b0, '0);
        sent++;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("packed_parameter_store verification clean");
    end else begin
      $display("packed_parameter_store verification failed");
    end
    $finish;
  end

endmodule
